/* rtl/modexp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types, constants and command/status structures.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned WIDTH         = 32;
  localparam int unsigned FERMAT_OFFSET = 2;

  typedef enum logic {
    OP_POWER   = 1'b0,
    OP_INVERSE = 1'b1
  } op_t;

  typedef struct packed {
    logic             opcode;
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] modulus;
  } in_beat_t;

  typedef struct packed {
    logic [WIDTH-1:0] result;
    logic             error;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new beat
    logic red_step;   // one restoring step of the base reduction
    logic mul_start;  // start acc * b
    logic sqr_start;  // start b * b
    logic mul_step;   // one shift-add step of the multiplier
    logic mul_commit; // write multiplier result to acc
    logic sqr_commit; // write multiplier result to b
    logic exp_shift;  // advance to the next exponent bit
    logic out_load;   // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic red_done;
    logic mul_done;
    logic exp_bit;
    logic last_bit;
    logic bad;        // error case, no computation needed
  } sts_t;

endpackage

/* rtl/modexp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand registers, bit-serial reducer and shift-add modular multiplier.
// ----------------------------------------------------------------------------
module modexp_datapath (
  input  logic                    clk,
  input  modexp_pkg::cmd_t        cmd,
  input  modexp_pkg::in_beat_t    in_beat,
  output modexp_pkg::sts_t        sts,
  output modexp_pkg::out_beat_t   out_beat
);

  localparam int unsigned WIDTH = modexp_pkg::WIDTH;
  localparam int unsigned CW    = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] e;
  logic [CW-1:0]    bit_cnt;
  logic             bad;
  logic             zero_exp;

  // Reduction: restoring division remainder, one base bit per step.
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH-1:0] red_src;
  logic [CW-1:0]    red_cnt;

  // Multiplier state.
  logic [WIDTH-1:0] ma;
  logic [WIDTH-1:0] mb;
  logic [WIDTH-1:0] macc;
  logic [CW-1:0]    mcnt;

  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_r;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] sum_r;
  logic [WIDTH-1:0] m_eff;
  logic [WIDTH-1:0] exp_sel;

  // Modulus-derived values for a new beat.
  always_comb begin
    m_eff = in_beat.modulus;
    if (in_beat.opcode == modexp_pkg::OP_INVERSE) begin
      exp_sel = m_eff - WIDTH'(modexp_pkg::FERMAT_OFFSET);
    end else begin
      exp_sel = in_beat.exponent;
    end
  end

  // Add-mod steps of the multiplier: doubling then conditional add.
  always_comb begin
    dbl   = {1'b0, macc} + {1'b0, macc};
    dbl_r = (dbl >= {1'b0, m}) ? WIDTH'(dbl - {1'b0, m}) : dbl[WIDTH-1:0];
    sum   = {1'b0, dbl_r} + {1'b0, ma};
    if (mb[WIDTH-1]) begin
      sum_r = (sum >= {1'b0, m}) ? WIDTH'(sum - {1'b0, m}) : sum[WIDTH-1:0];
    end else begin
      sum_r = dbl_r;
    end
    rem_sh = {b, red_src[WIDTH-1]};
  end

  // Operand and counter registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m        <= m_eff;
      e        <= exp_sel;
      b        <= '0;
      red_src  <= in_beat.base;
      red_cnt  <= '0;
      acc      <= WIDTH'(1);
      bit_cnt  <= '0;
      bad      <= (m_eff == '0) ||
                  ((in_beat.opcode == modexp_pkg::OP_INVERSE) &&
                   (m_eff < WIDTH'(modexp_pkg::FERMAT_OFFSET)));
      zero_exp <= (exp_sel == '0);
    end
    if (cmd.red_step) begin
      b       <= (rem_sh >= {1'b0, m}) ? WIDTH'(rem_sh - {1'b0, m}) : rem_sh[WIDTH-1:0];
      red_src <= red_src << 1;
      red_cnt <= red_cnt + CW'(1);
    end
    if (cmd.mul_start) begin
      ma   <= acc;
      mb   <= b;
      macc <= '0;
      mcnt <= '0;
    end
    if (cmd.sqr_start) begin
      ma   <= b;
      mb   <= b;
      macc <= '0;
      mcnt <= '0;
    end
    if (cmd.mul_step) begin
      macc <= sum_r;
      mb   <= mb << 1;
      mcnt <= mcnt + CW'(1);
    end
    if (cmd.mul_commit) begin
      acc <= macc;
    end
    if (cmd.sqr_commit) begin
      b <= macc;
    end
    if (cmd.exp_shift) begin
      e       <= e >> 1;
      bit_cnt <= bit_cnt + CW'(1);
    end
    if (cmd.out_load) begin
      out_beat.error  <= bad;
      out_beat.result <= bad ? '0 : acc;
    end
  end

  assign sts.red_done = (red_cnt == CW'(WIDTH));
  assign sts.mul_done = (mcnt == CW'(WIDTH));
  assign sts.exp_bit  = e[0];
  assign sts.last_bit = (bit_cnt == CW'(WIDTH - 1)) || zero_exp;
  assign sts.bad      = bad;

endmodule

/* rtl/modexp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences reduction, multiply and square steps and the beat handshake.
// ----------------------------------------------------------------------------
module modexp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  modexp_pkg::sts_t  sts,
  output modexp_pkg::cmd_t  cmd
);

  modexp_pkg::state_t state;
  modexp_pkg::state_t state_next;
  logic               out_valid_next;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= modexp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    in_stall       = (state != modexp_pkg::ST_IDLE);
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (sts.bad) begin
          state_next = modexp_pkg::ST_DONE;
        end else if (sts.red_done) begin
          if (sts.exp_bit) begin
            cmd.mul_start = 1'b1;
            state_next    = modexp_pkg::ST_MUL;
          end else begin
            cmd.sqr_start = 1'b1;
            state_next    = modexp_pkg::ST_SQR;
          end
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      modexp_pkg::ST_MUL: begin
        if (sts.mul_done) begin
          cmd.mul_commit = 1'b1;
          cmd.sqr_start  = 1'b1;
          state_next     = modexp_pkg::ST_SQR;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      modexp_pkg::ST_SQR: begin
        if (sts.mul_done) begin
          cmd.sqr_commit = 1'b1;
          state_next     = modexp_pkg::ST_NEXT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      modexp_pkg::ST_NEXT: begin
        if (sts.last_bit) begin
          state_next = modexp_pkg::ST_DONE;
        end else begin
          cmd.exp_shift = 1'b1;
          state_next    = modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = modexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = modexp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Square-and-multiply power and Fermat inverse modulo a 32-bit modulus.
// ----------------------------------------------------------------------------
// Sequence: 32 reduction steps of the base, then per exponent bit a multiply
// if the bit is set and a square (all 32 bits are walked), then the output load;
// a zero exponent finishes after the first bit, an error beat skips to the load.
// One beat at a time; a new beat is taken in the cycle after the result loads.
// Reset clears the controller and the output valid; payload is not reset.
module modular_exponentiation (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  modexp_pkg::in_beat_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output modexp_pkg::out_beat_t  out_data
);

  modexp_pkg::cmd_t cmd;
  modexp_pkg::sts_t sts;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  modexp_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_beat  (in_data),
    .sts      (sts),
    .out_beat (out_data)
  );

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // Once a beat is taken the input stalls while it is worked on.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("input accepted while busy");

  // Error beats carry a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.result == '0)
    else $error("error beat with non-zero result");

endmodule
